// ===== design/pst_pkg.sv =====
// Shared widths, codes and record types for the priority task scheduler.
// Used by the slot cell, the statistics unit and the top level.
package pst_pkg;

    localparam int MAX_TASKS = 64;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    localparam int PRIO_W  = 4;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 16;
    localparam int CNT_W   = 16;
    localparam int SUM_W   = 40;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 200;
    localparam int M_USER_W = 2;

    localparam logic CMD_ADD      = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    localparam logic [1:0] STATUS_DISPATCHED = 2'd0;
    localparam logic [1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [1:0] STATUS_ADDED      = 2'd2;
    localparam logic [1:0] STATUS_FULL       = 2'd3;

    // One table slot
    typedef struct packed {
        logic               valid;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
        logic [ID_W-1:0]    id;
    } slot_t;

    // Search token that travels down the row of cells
    typedef struct packed {
        logic               pulse;
        logic               have;
        logic [PRIO_W-1:0]  prio;
        logic [IDX_W-1:0]   idx;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
        logic [ID_W-1:0]    id;
    } tok_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic               add_en;
        logic               shift_en;
        logic [IDX_W-1:0]   shift_idx;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
        logic [ID_W-1:0]    id;
    } ctl_t;

    // Timing figures from the statistics unit
    typedef struct packed {
        logic [TIME_W-1:0] task_wait;
        logic [TIME_W-1:0] turnaround_time;
        logic [CNT_W-1:0]  tasks_done;
        logic [SUM_W-1:0]  total_wait;
        logic [SUM_W-1:0]  total_turnaround;
    } stat_res_t;

    // Result record: status travels on tuser, the rest is the tdata image
    // with the task id in the lowest bits
    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         pad;
        logic [SUM_W-1:0]   total_turnaround;
        logic [SUM_W-1:0]   total_wait;
        logic [CNT_W-1:0]   tasks_done;
        logic [TIME_W-1:0]  turnaround_time;
        logic [TIME_W-1:0]  task_wait;
        logic [BURST_W-1:0] run_burst;
        logic [PRIO_W-1:0]  run_priority;
        logic [ID_W-1:0]    task_id;
    } res_t;

    function automatic logic [SUM_W-1:0] sat_add40(input logic [SUM_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - TIME_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ===== design/pst_cell.sv =====
// One slot of the task table with its stage of the priority search.
// Depends on pst_pkg for the slot, token and control records.
module pst_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [pst_pkg::IDX_W-1:0] cell_idx,
    input  pst_pkg::ctl_t           ctl,
    input  logic                    prev_valid,
    input  pst_pkg::slot_t          next_slot,
    input  pst_pkg::tok_t           tok_in,
    output pst_pkg::slot_t          slot,
    output pst_pkg::tok_t           tok_out
);
    import pst_pkg::*;

    slot_t slot_reg, slot_next;
    tok_t  tok_reg, tok_next;
    logic  take_add, take_shift;

    assign take_add   = ctl.add_en && !slot_reg.valid && prev_valid;
    assign take_shift = ctl.shift_en && (cell_idx >= ctl.shift_idx);

    always_comb begin
        slot_next = slot_reg;
        if (take_shift) begin
            // close the gap left by the dispatched task
            slot_next = next_slot;
        end else if (take_add) begin
            slot_next.valid   = 1'b1;
            slot_next.prio    = ctl.prio;
            slot_next.burst   = ctl.burst;
            slot_next.arrival = ctl.arrival;
            slot_next.id      = ctl.id;
        end
    end

    always_comb begin
        tok_next = tok_in;
        // strictly greater keeps the earliest added task among equals
        if (tok_in.pulse && slot_reg.valid && (!tok_in.have || slot_reg.prio > tok_in.prio))
        begin
            tok_next.have    = 1'b1;
            tok_next.prio    = slot_reg.prio;
            tok_next.idx     = cell_idx;
            tok_next.burst   = slot_reg.burst;
            tok_next.arrival = slot_reg.arrival;
            tok_next.id      = slot_reg.id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
            tok_reg.pulse  <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
            tok_reg.pulse  <= tok_next.pulse;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg.prio    <= slot_next.prio;
        slot_reg.burst   <= slot_next.burst;
        slot_reg.arrival <= slot_next.arrival;
        slot_reg.id      <= slot_next.id;
        tok_reg.have     <= tok_next.have;
        tok_reg.prio     <= tok_next.prio;
        tok_reg.idx      <= tok_next.idx;
        tok_reg.burst    <= tok_next.burst;
        tok_reg.arrival  <= tok_next.arrival;
        tok_reg.id       <= tok_next.id;
    end

    assign slot    = slot_reg;
    assign tok_out = tok_reg;

endmodule

// ===== design/pst_stats.sv =====
// Clock, dispatch counter and saturating totals of the scheduler.
// Depends on pst_pkg; works out the figures of one dispatch in the steps p1, p2 and p3.
module pst_stats (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  pst_pkg::tok_t              best,
    output logic [pst_pkg::TIME_W-1:0] cur_time,
    output logic                       done,
    output pst_pkg::stat_res_t         res
);
    import pst_pkg::*;

    logic [TIME_W-1:0]  time_reg, time_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   wsum_reg, wsum_next;
    logic [SUM_W-1:0]   tsum_reg, tsum_next;
    logic [TIME_W-1:0]  wait_reg, turn_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               p1_reg, p2_reg, p3_reg;

    always_comb begin
        time_next  = time_reg;
        count_next = count_reg;
        wsum_next  = wsum_reg;
        tsum_next  = tsum_reg;
        if (start) begin
            time_next = time_reg + {{(TIME_W - BURST_W){1'b0}}, best.burst};
        end
        if (p1_reg) begin
            if (count_reg != {CNT_W{1'b1}}) begin
                count_next = count_reg + 1'b1;
            end
            wsum_next = sat_add40(wsum_reg, wait_reg);
        end
        if (p2_reg) begin
            tsum_next = sat_add40(tsum_reg, turn_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg  <= '0;
            count_reg <= '0;
            wsum_reg  <= '0;
            tsum_reg  <= '0;
            p1_reg    <= 1'b0;
            p2_reg    <= 1'b0;
            p3_reg    <= 1'b0;
        end else begin
            time_reg  <= time_next;
            count_reg <= count_next;
            wsum_reg  <= wsum_next;
            tsum_reg  <= tsum_next;
            p1_reg    <= start;
            p2_reg    <= p1_reg;
            p3_reg    <= p2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            wait_reg  <= time_reg - best.arrival;
            burst_reg <= best.burst;
        end
        if (p1_reg) begin
            // finish minus arrival is wait plus burst modulo the clock width
            turn_reg <= wait_reg + {{(TIME_W - BURST_W){1'b0}}, burst_reg};
        end
    end

    assign cur_time             = time_reg;
    assign done                 = p3_reg;
    assign res.task_wait        = wait_reg;
    assign res.turnaround_time  = turn_reg;
    assign res.tasks_done       = count_reg;
    assign res.total_wait       = wsum_reg;
    assign res.total_turnaround = tsum_reg;

endmodule

// ===== design/priority_task_scheduler_stats_unit.sv =====
// Non-preemptive priority task scheduler with waiting and turnaround statistics.
//
// Requests arrive on the s_ channel; tuser carries the command (add or dispatch),
// tdata the priority and burst of a task to add. Each request yields exactly one
// result on the m_ channel: tuser carries the status, tdata the task id, the
// dispatched task's priority and burst, its waiting and turnaround times, the
// dispatch count and the totals.
// The table is a row of MAX_TASKS cells kept in order of addition. A dispatch
// sends a search token down the row, one cell per cycle, then shifts the later
// cells down by one, in the same cycle as the statistics unit starts.
// An add, a full-table add or an empty dispatch goes from acceptance through
// ST_FINISH to the output register; a dispatch passes ST_SCAN, ST_STATS and
// ST_FINISH, its time set by the token walk along the cell row.
// One request is in flight at a time; a new request is accepted while the
// previous result still waits in the output register.
// A stalled receiver holds the result register; a finished request then waits
// until the register frees, and no new request is taken meanwhile.
// Reset (aresetn low, synchronous) empties the table and clears time, ids,
// count and totals; no clearing pass is needed.
module priority_task_scheduler_stats_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pst_pkg::S_DATA_W-1:0] s_tdata,  // task_priority[3:0], task_burst[19:4], zero pad
    input  logic [0:0]                   s_tuser,  // command[0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pst_pkg::M_DATA_W-1:0] m_tdata,  // task_id, run_priority, run_burst,
                                                   // task_wait, turnaround_time, tasks_done,
                                                   // total_wait, total_turnaround, zero pad
    output logic [pst_pkg::M_USER_W-1:0] m_tuser   // status[1:0]
);
    import pst_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_STATS  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    res_t              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_data_reg, m_data_next;

    slot_t             slot_w [MAX_TASKS];
    tok_t              tok_w  [MAX_TASKS+1];
    logic [MAX_TASKS-1:0] valid_vec;
    ctl_t              ctl;
    tok_t              tok_last;
    logic              s_accept, table_full, table_empty, scan_start, out_free;
    logic              stats_done;
    logic [TIME_W-1:0] cur_time;
    stat_res_t         stats_res;

    assign s_accept    = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign table_full  = slot_w[MAX_TASKS-1].valid;
    assign table_empty = !slot_w[0].valid;
    assign scan_start  = s_accept && (s_tuser[0] == CMD_DISPATCH) && !table_empty;
    assign tok_last    = tok_w[MAX_TASKS];
    assign out_free    = !m_valid_reg || m_tready;

    always_comb begin
        ctl.add_en    = s_accept && (s_tuser[0] == CMD_ADD);
        ctl.shift_en  = (state_reg == ST_SCAN) && tok_last.pulse;
        ctl.shift_idx = tok_last.idx;
        ctl.prio      = s_tdata[PRIO_W-1:0];
        ctl.burst     = s_tdata[PRIO_W+BURST_W-1:PRIO_W];
        ctl.arrival   = cur_time;
        ctl.id        = next_id_reg;
    end

    // token entering the first cell
    always_comb begin
        tok_w[0]       = '0;
        tok_w[0].pulse = scan_start;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            logic  prev_valid;
            slot_t next_slot;
            if (gi == 0) begin : g_first
                assign prev_valid = 1'b1;
            end else begin : g_mid
                assign prev_valid = slot_w[gi-1].valid;
            end
            if (gi == MAX_TASKS - 1) begin : g_last
                assign next_slot = '0;
            end else begin : g_inner
                assign next_slot = slot_w[gi+1];
            end
            pst_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cell_idx   (IDX_W'(gi)),
                .ctl        (ctl),
                .prev_valid (prev_valid),
                .next_slot  (next_slot),
                .tok_in     (tok_w[gi]),
                .slot       (slot_w[gi]),
                .tok_out    (tok_w[gi+1])
            );
            assign valid_vec[gi] = slot_w[gi].valid;
        end
    endgenerate

    pst_stats u_stats (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.shift_en),
        .best     (tok_last),
        .cur_time (cur_time),
        .done     (stats_done),
        .res      (stats_res)
    );

    always_comb begin
        state_next   = state_reg;
        next_id_next = next_id_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_next = '0;
                    if (s_tuser[0] == CMD_ADD) begin
                        if (table_full) begin
                            res_next.status = STATUS_FULL;
                        end else begin
                            res_next.status  = STATUS_ADDED;
                            res_next.task_id = next_id_reg;
                            next_id_next     = next_id_reg + 1'b1;
                        end
                        state_next = ST_FINISH;
                    end else if (table_empty) begin
                        res_next.status = STATUS_EMPTY;
                        state_next      = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tok_last.pulse) begin
                    res_next.status       = STATUS_DISPATCHED;
                    res_next.task_id      = tok_last.id;
                    res_next.run_priority = tok_last.prio;
                    res_next.run_burst    = tok_last.burst;
                    state_next            = ST_STATS;
                end
            end
            ST_STATS: begin
                if (stats_done) begin
                    res_next.task_wait        = stats_res.task_wait;
                    res_next.turnaround_time  = stats_res.turnaround_time;
                    res_next.tasks_done       = stats_res.tasks_done;
                    res_next.total_wait       = stats_res.total_wait;
                    res_next.total_turnaround = stats_res.total_turnaround;
                    state_next                = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            next_id_reg <= next_id_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg[M_DATA_W-1:0];
    assign m_tuser  = m_data_reg.status;

    // occupied slots always form a prefix of the row
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("table slots are not a prefix");

    // the slot being removed holds a task
    a_shift_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.shift_en |-> slot_w[ctl.shift_idx].valid)
        else $error("dispatch removes an empty slot");

    // an accepted add into a non-full table grows it by one
    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.add_en && !table_full) |=>
            ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
        else $error("add did not occupy one slot");

    // a search token leaves the row only during a scan
    a_token_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_last.pulse |-> (state_reg == ST_SCAN))
        else $error("search token outside a scan");

endmodule
